@@ hdl/mm_pkg.sv @@
// Shared types and constants for the matrix multiplier.
package mm_pkg;

	localparam int ELEM_W    = 16;
	localparam int PROD_W    = 40;
	localparam int MUL_W     = 2 * ELEM_W;
	localparam int IDX_W     = 4;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

	localparam logic [CFG_W-1:0] DIM_RESET = 5'd16;

	// One complete column of B waiting for the multiply-accumulate engine.
	typedef struct packed {
		logic             bank;
		logic [IDX_W-1:0] col;
	} job_t;

endpackage

@@ hdl/mm_elem_if.sv @@
// Input channel carrying one matrix element per request.
interface mm_elem_if;
	import mm_pkg::*;

	logic              valid;
	logic              ready;
	logic [ELEM_W-1:0] element;

	modport source (output valid, output element, input ready);
	modport sink (input valid, input element, output ready);
endinterface

@@ hdl/mm_prod_if.sv @@
// Output channel carrying one element of the product per request.
interface mm_prod_if;
	import mm_pkg::*;

	logic              valid;
	logic              ready;
	logic [PROD_W-1:0] product;
	logic [IDX_W-1:0]  row_index;
	logic [IDX_W-1:0]  col_index;
	logic              last;

	modport source (output valid, output product, output row_index, output col_index,
		output last, input ready);
	modport sink (input valid, input product, input row_index, input col_index,
		input last, output ready);
endinterface

@@ hdl/matrix_multiply.sv @@
// A column of the product is computed once its last B element has been accepted and queued.
// Each product row sums inner_dim products on the single shared multiply-accumulate unit, then is emitted.
// A column of B is therefore computed row by row for rows_a rows; A loads one per cycle while no column is pending.
// The front end holds two B columns, so it takes the next column while one is computed.
// Reset (arst_n low) restores all dimensions to 16 and expects a new A; stores are not cleared.
module matrix_multiply #(
	parameter int MAX_DIM = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [mm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mm_pkg::CFG_W-1:0]     cfg_data,
	mm_elem_if.sink                      elem_ch,
	mm_prod_if.source                    prod_ch
);
	import mm_pkg::*;

	localparam int DW      = $clog2(MAX_DIM + 1);
	localparam int AW      = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
	localparam int KW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int A_DEPTH = MAX_DIM * MAX_DIM;
	localparam int B_DEPTH = 2 * (2 ** KW);

	logic [DW-1:0]     nr;
	logic [DW-1:0]     nk;
	logic              a_we;
	logic [AW-1:0]     a_waddr;
	logic [ELEM_W-1:0] a_wdata;
	logic [AW-1:0]     a_raddr;
	logic [ELEM_W-1:0] a_rdata;
	logic              b_we;
	logic [KW:0]       b_waddr;
	logic [ELEM_W-1:0] b_wdata;
	logic [KW:0]       b_raddr;
	logic [ELEM_W-1:0] b_rdata;
	logic              push;
	job_t              push_job;
	logic              pop_valid;
	logic              pop_ready;
	job_t              pop_job;
	logic              job_done;

	mm_front #(.MAX_DIM(MAX_DIM)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.elem_ch   (elem_ch),
		.nr        (nr),
		.nk        (nk),
		.a_we      (a_we),
		.a_waddr   (a_waddr),
		.a_wdata   (a_wdata),
		.b_we      (b_we),
		.b_waddr   (b_waddr),
		.b_wdata   (b_wdata),
		.push      (push),
		.push_job  (push_job),
		.job_done  (job_done)
	);

	mm_ram #(.WIDTH(ELEM_W), .DEPTH(A_DEPTH)) u_a_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (a_wdata),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	mm_ram #(.WIDTH(ELEM_W), .DEPTH(B_DEPTH)) u_b_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (b_wdata),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	mm_jobq u_jobq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job)
	);

	mm_back #(.MAX_DIM(MAX_DIM)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.nr        (nr),
		.nk        (nk),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.job_done  (job_done),
		.a_raddr   (a_raddr),
		.b_raddr   (b_raddr),
		.a_rdata   (a_rdata),
		.b_rdata   (b_rdata),
		.prod_ch   (prod_ch)
	);
endmodule

@@ hdl/mm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	assign rdata = rd_q;
endmodule

@@ hdl/mm_front.sv @@
// Front end: configuration, element intake, A and B storage writes, job issue.
module mm_front #(
	parameter int MAX_DIM = 16,
	localparam int DW = $clog2(MAX_DIM + 1),
	localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1,
	localparam int KW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mm_pkg::CFG_W-1:0]      cfg_data,
	mm_elem_if.sink                       elem_ch,
	output logic [DW-1:0]                 nr,
	output logic [DW-1:0]                 nk,
	output logic                          a_we,
	output logic [AW-1:0]                 a_waddr,
	output logic [mm_pkg::ELEM_W-1:0]     a_wdata,
	output logic                          b_we,
	output logic [KW:0]                   b_waddr,
	output logic [mm_pkg::ELEM_W-1:0]     b_wdata,
	output logic                          push,
	output mm_pkg::job_t                  push_job,
	input  logic                          job_done
);
	import mm_pkg::*;

	localparam int CW = $clog2(MAX_DIM * MAX_DIM + 1);
	localparam int TW = 2 * DW;

	logic [CFG_W-1:0] rows_a_q;
	logic [CFG_W-1:0] inner_dim_q;
	logic [CFG_W-1:0] cols_b_q;
	logic             loading_b_q;
	logic             bank_q;
	logic [CW-1:0]    a_cnt_q;
	logic [DW-1:0]    b_row_q;
	logic [DW-1:0]    b_col_q;
	logic [1:0]       pend_q;

	logic [DW-1:0] nc;
	logic          accept;
	logic          cfg_hit;
	logic [TW-1:0] a_total;
	logic [TW-1:0] a_next;
	logic [DW:0]   b_row_next;
	logic [DW:0]   b_col_next;
	logic          col_done;

	function automatic logic [DW-1:0] eff_dim(input logic [CFG_W-1:0] r);
		if (r == '0) begin
			return DW'(1);
		end else if (int'(r) > MAX_DIM) begin
			return DW'(MAX_DIM);
		end else begin
			return DW'(r);
		end
	endfunction

	assign nr = eff_dim(rows_a_q);
	assign nk = eff_dim(inner_dim_q);
	assign nc = eff_dim(cols_b_q);

	// A may only be overwritten once every queued column has been computed.
	assign elem_ch.ready = loading_b_q ? (pend_q != 2'd2) : (pend_q == 2'd0);
	assign accept = elem_ch.valid && elem_ch.ready;

	assign cfg_hit = cfg_we && (cfg_index == REG_ROWS_A || cfg_index == REG_INNER_DIM
		|| cfg_index == REG_COLS_B);

	assign a_total    = TW'(nr) * TW'(nk);
	assign a_next     = TW'(a_cnt_q) + TW'(1);
	assign b_row_next = {1'b0, b_row_q} + (DW + 1)'(1);
	assign b_col_next = {1'b0, b_col_q} + (DW + 1)'(1);
	assign col_done   = b_row_next >= {1'b0, nk};

	assign a_we    = accept && !loading_b_q;
	assign a_waddr = a_cnt_q[AW-1:0];
	assign a_wdata = elem_ch.element;
	assign b_we    = accept && loading_b_q;
	assign b_waddr = {bank_q, b_row_q[KW-1:0]};
	assign b_wdata = elem_ch.element;

	assign push          = accept && loading_b_q && col_done;
	assign push_job.bank = bank_q;
	assign push_job.col  = IDX_W'(b_col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= DIM_RESET;
			inner_dim_q <= DIM_RESET;
			cols_b_q    <= DIM_RESET;
			loading_b_q <= 1'b0;
			bank_q      <= 1'b0;
			a_cnt_q     <= '0;
			b_row_q     <= '0;
			b_col_q     <= '0;
			pend_q      <= '0;
		end else begin
			if (push && !job_done) begin
				pend_q <= pend_q + 2'd1;
			end else if (!push && job_done) begin
				pend_q <= pend_q - 2'd1;
			end

			if (cfg_we) begin
				case (cfg_index)
					REG_ROWS_A:    rows_a_q <= cfg_data;
					REG_INNER_DIM: inner_dim_q <= cfg_data;
					REG_COLS_B:    cols_b_q <= cfg_data;
					default: ;
				endcase
			end

			// Any register write restarts the stream at the start of a new A.
			if (cfg_hit) begin
				loading_b_q <= 1'b0;
				a_cnt_q     <= '0;
				b_row_q     <= '0;
				b_col_q     <= '0;
			end else if (accept) begin
				if (!loading_b_q) begin
					if (a_next >= a_total) begin
						a_cnt_q     <= '0;
						b_row_q     <= '0;
						b_col_q     <= '0;
						loading_b_q <= 1'b1;
					end else begin
						a_cnt_q <= CW'(a_next);
					end
				end else if (col_done) begin
					b_row_q <= '0;
					bank_q  <= !bank_q;
					if (b_col_next >= {1'b0, nc}) begin
						b_col_q     <= '0;
						loading_b_q <= 1'b0;
						a_cnt_q     <= '0;
					end else begin
						b_col_q <= DW'(b_col_next);
					end
				end else begin
					b_row_q <= DW'(b_row_next);
				end
			end
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n) pend_q != 2'd3)
		else $error("front: pending column count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !loading_b_q) |-> (pend_q == 2'd0))
		else $error("front: A written while columns still pending");
	assert property (@(posedge clk) disable iff (!arst_n) push |-> (pend_q != 2'd2))
		else $error("front: column issued with both B banks busy");
`endif
endmodule

@@ hdl/mm_jobq.sv @@
// Two-entry queue of completed B columns between front end and MAC engine.
module mm_jobq (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  mm_pkg::job_t push_job,
	output logic         pop_valid,
	input  logic         pop_ready,
	output mm_pkg::job_t pop_job
);
	import mm_pkg::*;

	job_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop_valid = cnt_q != 2'd0;
	assign pop_job   = slot_q[rd_q];
	assign pop       = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n) push |-> (cnt_q != 2'd2 || pop))
		else $error("jobq: push into a full queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> wr_q == rd_q)
		else $error("jobq: pointers disagree on an empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("jobq: count out of range");
`endif
endmodule

@@ hdl/mm_back.sv @@
// Back end: one shared multiply-accumulate unit computing a column of the product.
module mm_back #(
	parameter int MAX_DIM = 16,
	localparam int DW = $clog2(MAX_DIM + 1),
	localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1,
	localparam int KW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [DW-1:0]             nr,
	input  logic [DW-1:0]             nk,
	input  logic                      pop_valid,
	output logic                      pop_ready,
	input  mm_pkg::job_t              pop_job,
	output logic                      job_done,
	output logic [AW-1:0]             a_raddr,
	output logic [KW:0]               b_raddr,
	input  logic [mm_pkg::ELEM_W-1:0] a_rdata,
	input  logic [mm_pkg::ELEM_W-1:0] b_rdata,
	mm_prod_if.source                 prod_ch
);
	import mm_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]    state_q;
	job_t          job_q;
	logic [KW-1:0] i_q;
	logic [KW-1:0] k_q;
	logic [AW-1:0] a_addr_q;
	logic          dcnt_q;
	logic          v_s1;
	logic          v_s2;
	logic          first_s1;
	logic          first_s2;
	logic          out_valid_q;

	logic signed [MUL_W-1:0]  prod_s2;
	logic signed [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0]        product_q;
	logic [IDX_W-1:0]         row_q;
	logic [IDX_W-1:0]         col_q;
	logic                     last_q;

	logic issue;
	logic last_k;
	logic last_row;
	logic out_load;

	assign issue    = state_q == ST_RUN;
	assign last_k   = k_q == KW'(nk - DW'(1));
	assign last_row = i_q == KW'(nr - DW'(1));
	assign out_load = (state_q == ST_EMIT) && (!out_valid_q || prod_ch.ready);

	assign pop_ready = state_q == ST_IDLE;
	assign job_done  = out_load && last_row;

	// Element (i, k) of A sits at k*rows + i; the address steps by rows per k.
	assign a_raddr = a_addr_q;
	assign b_raddr = {job_q.bank, k_q};

	assign prod_ch.valid     = out_valid_q;
	assign prod_ch.product   = product_q;
	assign prod_ch.row_index = row_q;
	assign prod_ch.col_index = col_q;
	assign prod_ch.last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			job_q       <= '0;
			i_q         <= '0;
			k_q         <= '0;
			a_addr_q    <= '0;
			dcnt_q      <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			first_s1    <= 1'b0;
			first_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1     <= issue;
			first_s1 <= issue && (k_q == '0);
			v_s2     <= v_s1;
			first_s2 <= first_s1;

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (prod_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						job_q    <= pop_job;
						i_q      <= '0;
						k_q      <= '0;
						a_addr_q <= '0;
						state_q  <= ST_RUN;
					end
				end
				ST_RUN: begin
					k_q      <= k_q + KW'(1);
					a_addr_q <= a_addr_q + AW'(nr);
					if (last_k) begin
						dcnt_q  <= 1'b0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					dcnt_q <= 1'b1;
					if (dcnt_q) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						if (last_row) begin
							state_q <= ST_IDLE;
						end else begin
							i_q      <= i_q + KW'(1);
							k_q      <= '0;
							a_addr_q <= AW'(i_q) + AW'(1);
							state_q  <= ST_RUN;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(a_rdata) * $signed(b_rdata);
		if (v_s2) begin
			acc_q <= (first_s2 ? '0 : acc_q) + {{(PROD_W - MUL_W){prod_s2[MUL_W-1]}}, prod_s2};
		end
		if (out_load) begin
			product_q <= acc_q;
			row_q     <= IDX_W'(i_q);
			col_q     <= job_q.col;
			last_q    <= last_row;
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (state_q == ST_RUN || state_q == ST_DRAIN))
		else $error("back: accumulation outside a row computation");
	assert property (@(posedge clk) disable iff (!arst_n) out_load |-> (!v_s1 && !v_s2))
		else $error("back: sum taken before the pipeline drained");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (int'(i_q) < int'(nr)))
		else $error("back: row index beyond the row count");
`endif
endmodule
